>>> sv/dlsc_pkg.sv
`timescale 1ns / 1ps

package dlsc_pkg;

    // Verdict codes, in order of check priority
    localparam logic [1:0] VERDICT_FOUND  = 2'd0;
    localparam logic [1:0] VERDICT_FORMAT = 2'd1;
    localparam logic [1:0] VERDICT_INDEX  = 2'd2;
    localparam logic [1:0] VERDICT_CRC    = 2'd3;

    localparam logic [31:0] CRC_PRESET = 32'hf597a6cf;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    // Label strings, first character in the top byte
    localparam logic [63:0] LABEL_MAGIC = "LABELONE";
    localparam logic [63:0] LABEL_TYPE  = "LVM2 001";

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] body_offset;
    } t_result;

    // Pick character idx of an 8-character string
    function automatic logic [7:0] str_byte(input logic [63:0] str, input logic [2:0] idx);
        logic [5:0] sh;
        begin
            sh = 6'(7 - idx) << 3;
            str_byte = 8'(str >> sh);
        end
    endfunction

    // Advance a reflected CRC-32 by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        begin
            r = crc ^ {24'd0, b};
            for (int i = 0; i < 8; i++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            crc_byte = r;
        end
    endfunction

endpackage

>>> sv/dlsc_scan.sv
`timescale 1ns / 1ps

module dlsc_scan #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [7:0]            i_data_byte,
    input  logic [1:0]            i_sector_number,
    output logic                  o_last,
    output dlsc_pkg::t_result     o_result
);

    localparam int PW = $clog2(SECTOR_BYTES);
    localparam logic [PW-1:0] LAST_POS = PW'(SECTOR_BYTES - 1);

    logic [PW-1:0]   r_pos,    n_pos;
    logic [31:0]     r_crc,    n_crc;
    logic [3:0][7:0] r_stored, n_stored;
    logic [3:0][7:0] r_offset, n_offset;
    logic            r_fmt_ok, n_fmt_ok;
    logic            r_idx_ok, n_idx_ok;
    logic [7:0]      want_idx;

    assign o_last = (r_pos == LAST_POS);
    assign want_idx = (r_pos == PW'(8)) ? {6'd0, i_sector_number} : 8'd0;

    // Check and collect one byte of the sector
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_stored = r_stored;
        n_offset = r_offset;
        n_fmt_ok = r_fmt_ok;
        n_idx_ok = r_idx_ok;
        if (r_pos < PW'(8)) begin
            if (i_data_byte != dlsc_pkg::str_byte(dlsc_pkg::LABEL_MAGIC, r_pos[2:0])) begin
                n_fmt_ok = 1'b0;
            end
        end else if (r_pos < PW'(16)) begin
            if (i_data_byte != want_idx) begin
                n_idx_ok = 1'b0;
            end
        end else if (r_pos < PW'(20)) begin
            n_stored[r_pos[1:0]] = i_data_byte;
        end else begin
            if (r_pos < PW'(24)) begin
                n_offset[r_pos[1:0]] = i_data_byte;
            end else if (r_pos < PW'(32)) begin
                if (i_data_byte != dlsc_pkg::str_byte(dlsc_pkg::LABEL_TYPE, r_pos[2:0])) begin
                    n_fmt_ok = 1'b0;
                end
            end
            n_crc = dlsc_pkg::crc_byte(r_crc, i_data_byte);
        end
        n_pos = r_pos + PW'(1);
    end

    // Form the verdict from the updated checks
    always_comb begin
        o_result.body_offset = 32'd0;
        if (!n_fmt_ok) begin
            o_result.verdict = dlsc_pkg::VERDICT_FORMAT;
        end else if (!n_idx_ok) begin
            o_result.verdict = dlsc_pkg::VERDICT_INDEX;
        end else if (n_crc != n_stored) begin
            o_result.verdict = dlsc_pkg::VERDICT_CRC;
        end else begin
            o_result.verdict = dlsc_pkg::VERDICT_FOUND;
            o_result.body_offset = n_offset;
        end
    end

    // Hold control state; restart at the end of each sector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= dlsc_pkg::CRC_PRESET;
            r_fmt_ok <= 1'b1;
            r_idx_ok <= 1'b1;
        end else if (i_go) begin
            if (o_last) begin
                r_pos    <= '0;
                r_crc    <= dlsc_pkg::CRC_PRESET;
                r_fmt_ok <= 1'b1;
                r_idx_ok <= 1'b1;
            end else begin
                r_pos    <= n_pos;
                r_crc    <= n_crc;
                r_fmt_ok <= n_fmt_ok;
                r_idx_ok <= n_idx_ok;
            end
        end
    end

    // Capture stored CRC and offset bytes
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_stored <= n_stored;
            r_offset <= n_offset;
        end
    end

endmodule

>>> sv/disk_label_sector_checker_core.sv
`timescale 1ns / 1ps
// The last byte of a sector passes through the input register, then loads the
// result register; that load waits while an earlier result is still unread.
// One byte per cycle while the input does not stall; the per-byte CRC update sits
// between the input register and the result register, one byte step per clock.
// One result per sector; the input stalls only while a result waits unread.
// Reset (synchronous, active low) clears the byte position, CRC and checks.

module disk_label_sector_checker_core #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [1:0]  i_sector_number,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_body_offset
);

    logic              r_v1;
    logic [7:0]        r_byte;
    logic [1:0]        r_sn;
    logic              r_out_valid;
    dlsc_pkg::t_result r_out;
    dlsc_pkg::t_result scan_result;
    logic              scan_last;
    logic              out_free;
    logic              s1_go;
    logic              in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_v1 && (!scan_last || out_free);
    assign o_in_stall = r_v1 && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Register the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_acc) begin
            r_v1 <= 1'b1;
        end else if (s1_go) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_data_byte;
            r_sn   <= i_sector_number;
        end
    end

    dlsc_scan #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (s1_go),
        .i_data_byte    (r_byte),
        .i_sector_number(r_sn),
        .o_last         (scan_last),
        .o_result       (scan_result)
    );

    // Load the result register on the last byte, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && scan_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && scan_last) begin
            r_out <= scan_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_out.verdict;
    assign o_body_offset = r_out.body_offset;

`ifndef SYNTHESIS
    // Offset is reported only with a found label
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict != dlsc_pkg::VERDICT_FOUND) |-> (o_body_offset == 32'd0))
        else $error("offset nonzero without a found label");

    // The byte stage blocks only behind an unread result
    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !s1_go) |-> (scan_last && r_out_valid && i_out_stall))
        else $error("byte stage blocked without cause");

    // Every finished sector raises the result valid
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && scan_last) |=> o_out_valid)
        else $error("result lost at end of sector");
`endif

endmodule
